// ===== src/hed_pkg.sv =====
// Shared types, character codes and hex helpers for the escape decoder.
`default_nettype none
package hed_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_BSL  = 2'd1;
  localparam logic [1:0] PH_X    = 2'd2;
  localparam logic [1:0] PH_X1   = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_end;
  } ent_t;

  typedef struct packed {
    logic [1:0]     cnt;
    ent_t [2:0]     ent;
  } dec_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // letters of either case: low nibble 1..6 plus 9 gives 10..15
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return is_digit(c) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

endpackage
`default_nettype wire

// ===== src/hed_decode.sv =====
// Escape state and the decode of one word into up to three result words.
`default_nettype none
module hed_decode import hed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       string_last,
  output dec_res_t        res
);

  logic [1:0] phase, phase_next;
  logic [7:0] held, held_next;

  always_comb begin
    logic [7:0] pb [4];
    logic [1:0] np;
    pb[0] = '0; pb[1] = '0; pb[2] = '0; pb[3] = '0;
    np = 2'd0;
    phase_next = phase;
    held_next = held;
    res = '0;

    // per phase: step the escape state and collect the bytes the current byte gives
    unique case (phase)
      PH_TEXT: begin
        if (in_byte == CH_BSLASH) begin
          phase_next = PH_BSL;
        end else begin
          pb[np] = in_byte; np = np + 2'd1;
        end
      end
      PH_BSL: begin
        if (in_byte == CH_ZERO) begin
          pb[np] = 8'h00; np = np + 2'd1;
          phase_next = PH_TEXT;
        end else if (in_byte == CH_X) begin
          phase_next = PH_X;
        end else if (in_byte == CH_BSLASH) begin
          phase_next = PH_BSL;
        end else begin
          pb[np] = in_byte; np = np + 2'd1;
          phase_next = PH_TEXT;
        end
      end
      PH_X: begin
        if (is_hex(in_byte)) begin
          held_next = in_byte;
          phase_next = PH_X1;
        end else begin
          pb[np] = CH_X; np = np + 2'd1;
          if (in_byte == CH_BSLASH) begin
            phase_next = PH_BSL;
          end else begin
            pb[np] = in_byte; np = np + 2'd1;
            phase_next = PH_TEXT;
          end
        end
      end
      PH_X1: begin
        if (is_hex(in_byte)) begin
          pb[np] = {hex_val(held), hex_val(in_byte)}; np = np + 2'd1;
          phase_next = PH_TEXT;
        end else begin
          pb[np] = CH_X; np = np + 2'd1;
          pb[np] = held; np = np + 2'd1;
          if (in_byte == CH_BSLASH) begin
            phase_next = PH_BSL;
          end else begin
            pb[np] = in_byte; np = np + 2'd1;
            phase_next = PH_TEXT;
          end
        end
      end
      default: phase_next = PH_TEXT;
    endcase

    if (string_last) begin
      // flush an unfinished \x sequence
      if (phase_next == PH_X) begin
        pb[np] = CH_X; np = np + 2'd1;
      end else if (phase_next == PH_X1) begin
        pb[np] = CH_X; np = np + 2'd1;
        pb[np] = held_next; np = np + 2'd1;
      end
      phase_next = PH_TEXT;
      held_next = '0;
    end

    if (np == 2'd0 && string_last) begin
      res.cnt = 2'd1;
      res.ent[0] = '{out_byte: 8'h00, has_byte: 1'b0, run_last: 1'b1, string_end: 1'b1};
    end else begin
      res.cnt = np;
      for (int k = 0; k < 3; k++) begin
        res.ent[k].out_byte = pb[k];
        res.ent[k].has_byte = 1'b1;
        res.ent[k].run_last = (2'(k) == np - 2'd1);
        res.ent[k].string_end = (2'(k) == np - 2'd1) && string_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      held <= '0;
    end else if (take) begin
      phase <= phase_next;
      held <= held_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/hed_emit.sv =====
// Result buffer: holds up to three decoded words and sends them one per cycle while m_tready is high.
`default_nettype none
module hed_emit import hed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire dec_res_t   res,
  output logic            can_load,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic [1:0]      m_tuser
);

  logic [1:0] cnt;
  ent_t [2:0] ent;
  logic       pop;

  assign pop = m_tvalid && m_tready;
  // buffer is free for a new set once the word now showing leaves
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = ent[0].out_byte;
  assign m_tlast  = ent[0].run_last;
  assign m_tuser  = {ent[0].string_end, ent[0].has_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= res.ent;
    end else if (pop) begin
      ent <= {ent[2], ent[2], ent[1]};
    end
  end

endmodule
`default_nettype wire

// ===== src/hex_escape_decoder.sv =====
// Top level of the backslash / hex escape decoder.
//
// Input stream (s_*): one escaped byte per word, tlast on the final byte of
// a string. Output stream (m_*): decoded bytes; tlast closes the words caused
// by one input byte, tuser[1] marks the final word of the string and
// tuser[0] is clear for the empty end word sent when nothing is left.
// An input word sits in an input register, is decoded there and its 0 to 3
// results are loaded into a result buffer that sends one word per cycle
// while m_tready is high. A byte passes the input register, then the buffer.
// Throughput: one input word per cycle while each byte gives at most one
// result and m_tready is high; a byte giving more results holds the input
// until only its last word is left, set by the single output port of the
// result buffer. Bytes giving no result are still taken one per cycle.
// Reset empties the input register and the result buffer and returns the escape state to plain text.
// A stalled receiver keeps the current word on m_tdata; the input register
// then fills and s_tready drops until the buffer drains.
`default_nettype none
module hex_escape_decoder import hed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,  // [7:0] in_byte
  input  wire logic       s_tlast,  // string_last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,  // [7:0] out_byte
  output logic            m_tlast,  // run_last
  output logic [1:0]      m_tuser   // [0] has_byte, [1] string_end
);

  logic       iv;
  logic [7:0] ibyte;
  logic       ilast;
  logic       take;
  logic       can_load;
  dec_res_t   res;

  assign take = iv && can_load;
  assign s_tready = !iv || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_tready) begin
      iv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ibyte <= s_tdata;
      ilast <= s_tlast;
    end
  end

  hed_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (ibyte),
    .string_last (ilast),
    .res         (res)
  );

  hed_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire
